FILE: hdl/vfcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared constants, types and helper functions of the voxel face mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

  // Chunk geometry (edge must be a power of two: addresses are packed x,y,z)
  localparam int CHUNK_EDGE  = 16;
  localparam int INDEX_LIMIT = 65535;

  // Field widths
  localparam int OP_W     = 2;
  localparam int POS_W    = 4;
  localparam int ID_W     = 16;
  localparam int MASK_W   = 6;
  localparam int DIR_W    = 3;
  localparam int BASE_W   = 16;
  localparam int COUNT_W  = 14;
  localparam int NUM_DIRS = 6;

  // Derived sizes
  localparam int COORD_W = $clog2(CHUNK_EDGE);
  localparam int ADDR_W  = 3 * COORD_W;
  localparam int DEPTH   = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
  localparam int ENTRY_W = ID_W + 1;
  localparam int WIDE_W  = BASE_W + 1;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Operation codes of an input item
  localparam logic [OP_W-1:0] OP_LOAD  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_MESH  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_BEGIN = OP_W'(2);

  // Face directions, in test order
  localparam logic [DIR_W-1:0] DIR_TOP    = DIR_W'(0);
  localparam logic [DIR_W-1:0] DIR_BOTTOM = DIR_W'(1);
  localparam logic [DIR_W-1:0] DIR_EAST   = DIR_W'(2);
  localparam logic [DIR_W-1:0] DIR_WEST   = DIR_W'(3);
  localparam logic [DIR_W-1:0] DIR_NORTH  = DIR_W'(4);
  localparam logic [DIR_W-1:0] DIR_SOUTH  = DIR_W'(5);
  localparam logic [DIR_W-1:0] DIR_COUNT  = DIR_W'(NUM_DIRS);

  // Coordinate arithmetic one bit wider than a position
  localparam logic [POS_W:0] ONE_EXT  = (POS_W + 1)'(1);
  localparam logic [POS_W:0] EDGE_EXT = (POS_W + 1)'(CHUNK_EDGE);

  // Vertex index arithmetic
  localparam logic [WIDE_W-1:0] LIMIT_W  = WIDE_W'(INDEX_LIMIT);
  localparam logic [WIDE_W-1:0] VTX_ONE  = WIDE_W'(4);
  localparam logic [WIDE_W-1:0] VTX_TWO  = WIDE_W'(8);

  // Last address of the voxel store
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_MESH,
    CMD_BEGIN
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } st_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [ADDR_W-1:0]  addr;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   z;
    logic [ENTRY_W-1:0] entry;
    logic [MASK_W-1:0]  mask;
  } cmd_item_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

  typedef struct packed {
    logic              in_range;
    logic [ADDR_W-1:0] addr;
  } nbr_t;

  // Store address of a voxel
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] x,
                                                  input logic [POS_W-1:0] y,
                                                  input logic [POS_W-1:0] z);
    return {x[COORD_W-1:0], y[COORD_W-1:0], z[COORD_W-1:0]};
  endfunction

  // Test a position against the chunk bounds
  function automatic logic in_chunk(input logic [POS_W-1:0] x,
                                    input logic [POS_W-1:0] y,
                                    input logic [POS_W-1:0] z);
    return ({1'b0, x} < EDGE_EXT) && ({1'b0, y} < EDGE_EXT) && ({1'b0, z} < EDGE_EXT);
  endfunction

  // Neighbour across one face: in-range flag and store address
  function automatic nbr_t nbr_of(input logic [POS_W-1:0] x,
                                  input logic [POS_W-1:0] y,
                                  input logic [POS_W-1:0] z,
                                  input logic [DIR_W-1:0] dir);
    logic [POS_W:0] nx;
    logic [POS_W:0] ny;
    logic [POS_W:0] nz;
    nbr_t           r;
    nx = {1'b0, x};
    ny = {1'b0, y};
    nz = {1'b0, z};
    case (dir)
      DIR_TOP:    ny = ny + ONE_EXT;
      DIR_BOTTOM: ny = ny - ONE_EXT;
      DIR_EAST:   nx = nx + ONE_EXT;
      DIR_WEST:   nx = nx - ONE_EXT;
      DIR_NORTH:  nz = nz - ONE_EXT;
      DIR_SOUTH:  nz = nz + ONE_EXT;
      default:    ;
    endcase
    // a step below zero wraps to all ones, which is past the edge as well
    r.in_range = (nx < EDGE_EXT) && (ny < EDGE_EXT) && (nz < EDGE_EXT);
    r.addr     = {nx[COORD_W-1:0], ny[COORD_W-1:0], nz[COORD_W-1:0]};
    return r;
  endfunction

endpackage

FILE: hdl/vfcm_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfcm_ifs
// Handshake channels of the mesher: input items, face results, register write.
// ----------------------------------------------------------------------------
interface vfcm_in_if;
  logic                        valid;
  logic                        ready;
  logic [vfcm_pkg::OP_W-1:0]   operation;
  logic [vfcm_pkg::POS_W-1:0]  pos_x;
  logic [vfcm_pkg::POS_W-1:0]  pos_y;
  logic [vfcm_pkg::POS_W-1:0]  pos_z;
  logic [vfcm_pkg::ID_W-1:0]   block_id;
  logic                        renderable;
  logic [vfcm_pkg::MASK_W-1:0] border_opaque;

  modport source (output valid, operation, pos_x, pos_y, pos_z, block_id, renderable,
                  border_opaque, input ready);
  modport sink   (input valid, operation, pos_x, pos_y, pos_z, block_id, renderable,
                  border_opaque, output ready);
endinterface

interface vfcm_out_if;
  logic                        valid;
  logic                        ready;
  logic [vfcm_pkg::POS_W-1:0]  face_x;
  logic [vfcm_pkg::POS_W-1:0]  face_y;
  logic [vfcm_pkg::POS_W-1:0]  face_z;
  logic [vfcm_pkg::DIR_W-1:0]  face_dir;
  logic [vfcm_pkg::ID_W-1:0]   face_block;
  logic [vfcm_pkg::BASE_W-1:0] base_vertex;
  logic                        last_face;

  modport source (output valid, face_x, face_y, face_z, face_dir, face_block, base_vertex,
                  last_face, input ready);
  modport sink   (input valid, face_x, face_y, face_z, face_dir, face_block, base_vertex,
                  last_face, output ready);
endinterface

interface vfcm_cfg_if;
  logic valid;
  logic ready;
  logic world_present;

  modport source (output valid, world_present, input ready);
  modport sink   (input valid, world_present, output ready);
endinterface

FILE: hdl/vfcm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfcm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vfcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/vfcm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfcm_front
// Accepts input items, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module vfcm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  vfcm_in_if.sink              in_ch,
  input  vfcm_pkg::back_stat_t stat,
  output logic                 q_valid,
  output vfcm_pkg::cmd_item_t  q_head
);

  vfcm_pkg::cmd_item_t             q_mem_r [vfcm_pkg::QDEPTH];
  logic [vfcm_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [vfcm_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [vfcm_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  vfcm_pkg::cmd_item_t             item;
  logic                            keep;
  logic                            in_range;
  logic                            accept;
  logic                            push;

  assign in_range = vfcm_pkg::in_chunk(in_ch.pos_x, in_ch.pos_y, in_ch.pos_z);
  assign in_ch.ready = (cnt_r != vfcm_pkg::QCNT_W'(vfcm_pkg::QDEPTH)) && !stat.clearing;
  assign accept  = in_ch.valid && in_ch.ready;
  assign push    = accept && keep;
  assign q_valid = (cnt_r != '0);
  assign q_head  = q_mem_r[rd_ptr_r];

  // classify: drop outside coordinates and unknown operations
  always_comb begin
    item.cmd   = vfcm_pkg::CMD_LOAD;
    item.addr  = vfcm_pkg::cell_addr(in_ch.pos_x, in_ch.pos_y, in_ch.pos_z);
    item.x     = in_ch.pos_x;
    item.y     = in_ch.pos_y;
    item.z     = in_ch.pos_z;
    item.entry = {in_ch.renderable, in_ch.block_id};
    item.mask  = in_ch.border_opaque;
    keep       = 1'b0;
    case (in_ch.operation)
      vfcm_pkg::OP_LOAD: begin
        item.cmd = vfcm_pkg::CMD_LOAD;
        keep     = in_range;
      end
      vfcm_pkg::OP_MESH: begin
        item.cmd = vfcm_pkg::CMD_MESH;
        keep     = in_range;
      end
      vfcm_pkg::OP_BEGIN: begin
        item.cmd = vfcm_pkg::CMD_BEGIN;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // advance queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == vfcm_pkg::QPTR_W'(vfcm_pkg::QDEPTH - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
    end
    if (stat.pop) begin
      rd_ptr_nxt = (rd_ptr_r == vfcm_pkg::QPTR_W'(vfcm_pkg::QDEPTH - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
    end
    if (push && !stat.pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && stat.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

FILE: hdl/vfcm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfcm_back
// Executes queued commands: clears and writes the voxel store, reads a voxel
// and its six neighbours, and emits one result per visible face.
// ----------------------------------------------------------------------------
module vfcm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 world_present,
  input  logic                 q_valid,
  input  vfcm_pkg::cmd_item_t  q_head,
  output vfcm_pkg::back_stat_t stat,
  vfcm_out_if.source           out_ch
);

  vfcm_pkg::st_t                    state_r, state_nxt;
  logic [vfcm_pkg::ADDR_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic [vfcm_pkg::DIR_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic [vfcm_pkg::POS_W-1:0]       x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [vfcm_pkg::MASK_W-1:0]      mask_r, mask_nxt;
  logic [vfcm_pkg::ID_W-1:0]        own_id_r, own_id_nxt;
  logic                             nbr_in_r, nbr_in_nxt;
  logic [vfcm_pkg::NUM_DIRS-1:0]    vis_r, vis_nxt;
  logic [vfcm_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [vfcm_pkg::POS_W-1:0]       ox_r, oy_r, oz_r;
  logic [vfcm_pkg::DIR_W-1:0]       odir_r;
  logic [vfcm_pkg::ID_W-1:0]        oblock_r;
  logic [vfcm_pkg::BASE_W-1:0]      obase_r;
  logic                             olast_r;

  logic                             we;
  logic [vfcm_pkg::ADDR_W-1:0]      waddr;
  logic [vfcm_pkg::ENTRY_W-1:0]     wdata;
  logic [vfcm_pkg::ADDR_W-1:0]      raddr;
  logic [vfcm_pkg::ENTRY_W-1:0]     rdata;
  logic                             pop;
  logic                             emit;
  logic                             out_free;
  vfcm_pkg::nbr_t                   nb;
  logic [vfcm_pkg::DIR_W-1:0]       f_idx;
  logic                             face_vis;
  logic [vfcm_pkg::DIR_W-1:0]       sel_dir;
  logic [vfcm_pkg::NUM_DIRS-1:0]    rem;
  logic [vfcm_pkg::WIDE_W-1:0]      base_w;
  logic                             fits_now;
  logic                             fits_next;

  vfcm_ram #(
    .WIDTH (vfcm_pkg::ENTRY_W),
    .DEPTH (vfcm_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // neighbour to fetch next, and the face whose neighbour data is arriving
  assign nb       = vfcm_pkg::nbr_of(x_r, y_r, z_r, rd_idx_r);
  assign f_idx    = rd_idx_r - 1'b1;
  assign face_vis = nbr_in_r ? (rdata[vfcm_pkg::ID_W-1:0] == '0)
                             : (!world_present || !mask_r[f_idx]);

  // pick the lowest pending face
  always_comb begin
    sel_dir = '0;
    for (int i = vfcm_pkg::NUM_DIRS - 1; i >= 0; i--) begin
      if (vis_r[i]) begin
        sel_dir = vfcm_pkg::DIR_W'(i);
      end
    end
    rem          = vis_r;
    rem[sel_dir] = 1'b0;
  end

  // vertex index checks for this face and the one after it
  assign base_w    = vfcm_pkg::WIDE_W'({count_r, 2'b00});
  assign fits_now  = (base_w + vfcm_pkg::VTX_ONE) <= vfcm_pkg::LIMIT_W;
  assign fits_next = (base_w + vfcm_pkg::VTX_TWO) <= vfcm_pkg::LIMIT_W;

  assign out_free      = !out_valid_r || out_ch.ready;
  assign stat.clearing = (state_r == vfcm_pkg::ST_CLEAR);
  assign stat.pop      = pop;

  // next state and store control
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    rd_idx_nxt   = rd_idx_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    z_nxt        = z_r;
    mask_nxt     = mask_r;
    own_id_nxt   = own_id_r;
    nbr_in_nxt   = nbr_in_r;
    vis_nxt      = vis_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    we           = 1'b0;
    waddr        = q_head.addr;
    wdata        = q_head.entry;
    raddr        = q_head.addr;
    pop          = 1'b0;
    emit         = 1'b0;
    case (state_r)
      vfcm_pkg::ST_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_addr_r;
        wdata        = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == vfcm_pkg::CLR_LAST) begin
          state_nxt = vfcm_pkg::ST_IDLE;
        end
      end
      vfcm_pkg::ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_head.cmd)
            vfcm_pkg::CMD_LOAD: begin
              we = 1'b1;
            end
            vfcm_pkg::CMD_BEGIN: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            vfcm_pkg::CMD_MESH: begin
              // own voxel read goes out now; drop the item once overflowed
              if (!ovf_r) begin
                x_nxt      = q_head.x;
                y_nxt      = q_head.y;
                z_nxt      = q_head.z;
                mask_nxt   = q_head.mask;
                rd_idx_nxt = '0;
                vis_nxt    = '0;
                state_nxt  = vfcm_pkg::ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      vfcm_pkg::ST_READ: begin
        // issue the next neighbour read while the previous data comes back
        raddr      = nb.addr;
        nbr_in_nxt = nb.in_range;
        rd_idx_nxt = rd_idx_r + 1'b1;
        if (rd_idx_r == '0) begin
          if (rdata[vfcm_pkg::ID_W-1:0] != '0 && rdata[vfcm_pkg::ID_W]) begin
            own_id_nxt = rdata[vfcm_pkg::ID_W-1:0];
          end else begin
            state_nxt = vfcm_pkg::ST_IDLE;
          end
        end else begin
          vis_nxt[f_idx] = face_vis;
          if (rd_idx_r == vfcm_pkg::DIR_COUNT) begin
            state_nxt = vfcm_pkg::ST_EMIT;
          end
        end
      end
      vfcm_pkg::ST_EMIT: begin
        if (vis_r == '0) begin
          state_nxt = vfcm_pkg::ST_IDLE;
        end else if (out_free) begin
          if (!fits_now) begin
            ovf_nxt   = 1'b1;
            state_nxt = vfcm_pkg::ST_IDLE;
          end else begin
            emit      = 1'b1;
            count_nxt = count_r + 1'b1;
            vis_nxt   = rem;
            if (rem == '0) begin
              state_nxt = vfcm_pkg::ST_IDLE;
            end else if (!fits_next) begin
              // the next visible face would pass the index limit
              ovf_nxt   = 1'b1;
              state_nxt = vfcm_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = vfcm_pkg::ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vfcm_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      rd_idx_r    <= '0;
      vis_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_idx_r    <= rd_idx_nxt;
      vis_r       <= vis_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold item payload and load the result register
  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    mask_r   <= mask_nxt;
    own_id_r <= own_id_nxt;
    nbr_in_r <= nbr_in_nxt;
    if (emit) begin
      ox_r     <= x_r;
      oy_r     <= y_r;
      oz_r     <= z_r;
      odir_r   <= sel_dir;
      oblock_r <= own_id_r;
      obase_r  <= base_w[vfcm_pkg::BASE_W-1:0];
      olast_r  <= (rem == '0) || !fits_next;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.face_x      = ox_r;
  assign out_ch.face_y      = oy_r;
  assign out_ch.face_z      = oz_r;
  assign out_ch.face_dir    = odir_r;
  assign out_ch.face_block  = oblock_r;
  assign out_ch.base_vertex = obase_r;
  assign out_ch.last_face   = olast_r;

endmodule

FILE: hdl/voxel_face_culling_mesher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher_core
// Hidden-face culling for one 16x16x16 voxel chunk.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 4096-entry voxel store to zero, one entry
// a cycle, and takes no item until the sweep ends; register writes are taken
// throughout. Items pass through a two-entry command queue to the execution
// side, which owns the single-read-port voxel store. A load, begin or dropped
// item is handled in the idle state there. A mesh item issues the read of its
// voxel, then fetches that voxel and its six neighbours one read a cycle, then
// emits one visible face a cycle while the result channel does not stall.
// A mesh item on an empty or non-renderable voxel ends once its own voxel
// has been read. Write world_present only while the block is idle.
module voxel_face_culling_mesher_core (
  input  logic        clk,
  input  logic        rst_n,
  vfcm_in_if.sink     in_ch,
  vfcm_out_if.source  out_ch,
  vfcm_cfg_if.sink    cfg_ch
);

  logic                 world_present_r, world_present_nxt;
  logic                 q_valid;
  vfcm_pkg::cmd_item_t  q_head;
  vfcm_pkg::back_stat_t stat;

  // configuration register
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    world_present_nxt = world_present_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      world_present_nxt = cfg_ch.world_present;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      world_present_r <= 1'b0;
    end else begin
      world_present_r <= world_present_nxt;
    end
  end

  vfcm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .stat    (stat),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  vfcm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .world_present (world_present_r),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .stat          (stat),
    .out_ch        (out_ch)
  );

`ifndef SYNTHESIS
  // the store sweep starts right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> stat.clearing)
    else $error("store sweep not running after reset");

  // no item enters and no face leaves during the sweep
  a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> (!in_ch.ready && !out_ch.valid && !stat.pop))
    else $error("activity during store sweep");

  // vertex bases are whole quads
  a_base_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.base_vertex[1:0] == 2'b00))
    else $error("base vertex not a multiple of four");

  // a face direction is one of the six faces
  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.face_dir < vfcm_pkg::DIR_COUNT))
    else $error("face direction out of range");
`endif

endmodule
